### sv/ppm_pkg.sv
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared types and constants for the PPM frame decoder.
// ----------------------------------------------------------------------------
package ppm_pkg;

    localparam int NUM_CHANNELS = 8;

    localparam int TIME_W  = 16;
    localparam int SLOT_W  = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [TIME_W-1:0] SYNC_GAP_RST  = 16'd20000;
    localparam logic [TIME_W-1:0] PULSE_MIN_RST = 16'd3000;
    localparam logic [TIME_W-1:0] PULSE_MAX_RST = 16'd9000;
    localparam logic [SLOT_W-1:0] OK_AFTER_RST  = 4'd4;

    localparam logic [SLOT_W-1:0] MARKER_SLOT = 4'd6;
    localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(NUM_CHANNELS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_GAP  = 2'd0,
        CFG_PULSE_MIN = 2'd1,
        CFG_PULSE_MAX = 2'd2,
        CFG_OK_AFTER  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [TIME_W-1:0] sync_gap_ticks;
        logic [TIME_W-1:0] pulse_min_ticks;
        logic [TIME_W-1:0] pulse_max_ticks;
        logic [SLOT_W-1:0] ok_after_slot;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0] previous_capture;
        logic [SLOT_W-1:0] slot_counter;
        logic              frame_status;
    } t_state;

    typedef struct packed {
        logic              frame_ok;
        logic              channel_written;
        logic [SLOT_W-1:0] channel_index;
        logic [TIME_W-1:0] pulse_width;
        logic              sync_seen;
        logic              slot_marker;
    } t_result;

endpackage

### sv/ppm_cfg.sv
// ----------------------------------------------------------------------------
// ppm_cfg
// Configuration register bank, written through a plain write port.
// ----------------------------------------------------------------------------
module ppm_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ppm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ppm_pkg::TIME_W-1:0]       i_cfg_wdata,
    output ppm_pkg::t_cfg                    o_cfg
);

    ppm_pkg::t_cfg r_cfg;
    ppm_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (ppm_pkg::t_cfg_idx'(i_cfg_index))
                ppm_pkg::CFG_SYNC_GAP:  n_cfg.sync_gap_ticks  = i_cfg_wdata;
                ppm_pkg::CFG_PULSE_MIN: n_cfg.pulse_min_ticks = i_cfg_wdata;
                ppm_pkg::CFG_PULSE_MAX: n_cfg.pulse_max_ticks = i_cfg_wdata;
                ppm_pkg::CFG_OK_AFTER:
                    n_cfg.ok_after_slot = i_cfg_wdata[ppm_pkg::SLOT_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_gap_ticks  <= ppm_pkg::SYNC_GAP_RST;
            r_cfg.pulse_min_ticks <= ppm_pkg::PULSE_MIN_RST;
            r_cfg.pulse_max_ticks <= ppm_pkg::PULSE_MAX_RST;
            r_cfg.ok_after_slot   <= ppm_pkg::OK_AFTER_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### sv/ppm_step.sv
// ----------------------------------------------------------------------------
// ppm_step
// Interval and slot decode for one captured edge: subtract, compare, select.
// ----------------------------------------------------------------------------
module ppm_step (
    input  ppm_pkg::t_cfg                 i_cfg,
    input  ppm_pkg::t_state               i_state,
    input  logic [ppm_pkg::TIME_W-1:0]    i_capture_time,
    output ppm_pkg::t_state               o_state,
    output ppm_pkg::t_result              o_result
);

    logic [ppm_pkg::TIME_W-1:0] interval;
    logic                       sync;
    logic                       in_frame;
    logic                       pulse_ok;
    logic                       written;
    logic [ppm_pkg::SLOT_W-1:0] slot_eff;
    logic                       status;

    always_comb begin
        interval = i_capture_time - i_state.previous_capture;
        sync     = interval > i_cfg.sync_gap_ticks;
        in_frame = (i_state.slot_counter != '0)
                && (i_state.slot_counter <= ppm_pkg::LAST_SLOT);
        pulse_ok = (interval > i_cfg.pulse_min_ticks)
                && (interval < i_cfg.pulse_max_ticks);
        written  = 1'b0;
        slot_eff = '0;
        status   = i_state.frame_status;

        // sync restarts the frame and leaves status alone
        priority if (sync) begin
            slot_eff = '0;
        end else if (in_frame) begin
            slot_eff = i_state.slot_counter;
            if (pulse_ok) begin
                written = 1'b1;
                if (i_state.slot_counter > i_cfg.ok_after_slot) begin
                    status = 1'b1;
                end
            end else begin
                status = 1'b0;
            end
        end else begin
            // no sync yet, or past the last slot
            status   = 1'b0;
            slot_eff = '0;
        end

        o_state.previous_capture = i_capture_time;
        o_state.slot_counter     = slot_eff + 1'b1;
        o_state.frame_status     = status;

        o_result.frame_ok        = status;
        o_result.channel_written = written;
        o_result.channel_index   = written ? i_state.slot_counter : '0;
        o_result.pulse_width     = interval;
        o_result.sync_seen       = sync;
        o_result.slot_marker     = slot_eff == ppm_pkg::MARKER_SLOT;
    end

endmodule

### sv/ppm_frame_decoder.sv
// ----------------------------------------------------------------------------
// ppm_frame_decoder
// PPM frame decoder: turns edge capture timestamps into channel pulse widths
// and a frame status.
// ----------------------------------------------------------------------------
//
//  Port group   Direction  Handshake             Payload
//  ----------   ---------  --------------------  ---------------------------
//  capture in   in         i_valid / o_ready     i_capture_time
//  result out   out        o_valid / i_ready     o_frame_ok .. o_slot_marker
//  config       in         i_cfg_we (no wait)    i_cfg_index, i_cfg_wdata
//
//  One capture per cycle sustained while i_ready stays high. The result is
//  offered from the result register: the capture is held in the input
//  register, then one subtract and compare pass into the result register.
//  Reset (i_rst_n low at a clock edge) empties both stages, clears the
//  previous capture, slot counter and frame status, and loads register
//  defaults. A stalled result holds the result register; the input register
//  keeps taking a capture whenever the result register is free or drains.
// ----------------------------------------------------------------------------
module ppm_frame_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ppm_pkg::TIME_W-1:0]    i_capture_time,

    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_frame_ok,
    output logic                          o_channel_written,
    output logic [ppm_pkg::SLOT_W-1:0]    o_channel_index,
    output logic [ppm_pkg::TIME_W-1:0]    o_pulse_width,
    output logic                          o_sync_seen,
    output logic                          o_slot_marker,

    input  logic                          i_cfg_we,
    input  logic [ppm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ppm_pkg::TIME_W-1:0]    i_cfg_wdata
);

    ppm_pkg::t_cfg     cfg;
    ppm_pkg::t_state   r_state;
    ppm_pkg::t_state   n_state;
    ppm_pkg::t_result  n_result;
    ppm_pkg::t_result  r_result;

    logic                       r_in_valid;
    logic [ppm_pkg::TIME_W-1:0] r_in_capture;
    logic                       r_out_valid;
    logic                       advance;
    logic                       in_xfer;

    ppm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ppm_step u_step (
        .i_cfg          (cfg),
        .i_state        (r_state),
        .i_capture_time (r_in_capture),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    // Move the held capture into the result register when that register is
    // empty or its result transfers this cycle.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    // Input stage is free when empty or when its capture moves on.
    assign o_ready = !r_in_valid || advance;
    assign in_xfer = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
                // commit frame state only with the result it produced
                r_state     <= n_state;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: load on transfer, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_capture <= i_capture_time;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_frame_ok        = r_result.frame_ok;
    assign o_channel_written = r_result.channel_written;
    assign o_channel_index   = r_result.channel_index;
    assign o_pulse_width     = r_result.pulse_width;
    assign o_sync_seen       = r_result.sync_seen;
    assign o_slot_marker     = r_result.slot_marker;

endmodule
